// ===== src/sts_pkg.sv =====
// shared types, token codes and character helpers for the source token scanner
package sts_pkg;

  localparam int LINE_W      = 24;
  localparam int COL_W       = 16;
  localparam int INT_W       = 64;
  localparam int FRAC_W      = 60;
  localparam int FCNT_W      = 5;
  localparam int NLEN_W      = 16;
  localparam int MAX_FRAC    = 18;
  localparam int QDEPTH      = 4;
  localparam int QCNT_W      = 3;

  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};
  localparam logic [NLEN_W-1:0] NLEN_MAX = {NLEN_W{1'b1}};

  // token kinds
  localparam logic [4:0] KIND_LITERAL = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_STAR    = 5'd3;
  localparam logic [4:0] KIND_SLASH   = 5'd4;
  localparam logic [4:0] KIND_PLUS    = 5'd5;
  localparam logic [4:0] KIND_MINUS   = 5'd6;
  localparam logic [4:0] KIND_PERCENT = 5'd7;
  localparam logic [4:0] KIND_COMMA   = 5'd8;
  localparam logic [4:0] KIND_LPAREN  = 5'd9;
  localparam logic [4:0] KIND_RPAREN  = 5'd10;
  localparam logic [4:0] KIND_LBRACK  = 5'd11;
  localparam logic [4:0] KIND_RBRACK  = 5'd12;
  localparam logic [4:0] KIND_LBRACE  = 5'd13;
  localparam logic [4:0] KIND_RBRACE  = 5'd14;
  localparam logic [4:0] KIND_PIPE    = 5'd15;
  localparam logic [4:0] KIND_MAP     = 5'd16;
  localparam logic [4:0] KIND_COLON   = 5'd17;
  localparam logic [4:0] KIND_LT      = 5'd18;
  localparam logic [4:0] KIND_LE      = 5'd19;
  localparam logic [4:0] KIND_GT      = 5'd20;
  localparam logic [4:0] KIND_GE      = 5'd21;
  localparam logic [4:0] KIND_EQ      = 5'd22;
  localparam logic [4:0] KIND_END     = 5'd23;
  localparam logic [4:0] KIND_ERROR   = 5'd24;

  // literal kinds
  localparam logic [2:0] LIT_INT  = 3'd0;
  localparam logic [2:0] LIT_FRAC = 3'd1;

  // keyword candidates
  localparam logic [1:0] KW_NONE  = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;
  localparam logic [1:0] KW_NIL   = 2'd3;

  typedef struct packed {
    logic [4:0]              token_kind;
    logic [2:0]              literal_kind;
    logic [LINE_W-1:0]       line_number;
    logic [COL_W-1:0]        column_number;
    logic signed [INT_W-1:0] int_value;
    logic [FRAC_W-1:0]       fraction_digits;
    logic [FCNT_W-1:0]       fraction_count;
    logic [NLEN_W-1:0]       name_length;
    logic                    last;
  } res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]});
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_letter(c) || is_num_char(c) || (c inside {8'h5f, 8'h3f});
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] kw);
    case (kw)
      KW_TRUE:  return 3'd4;
      KW_FALSE: return 3'd5;
      KW_NIL:   return 3'd3;
      default:  return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] idx);
    logic [39:0] text;
    text = '0;
    case (kw)
      KW_TRUE:  text = {8'h00, "eurt"};
      KW_FALSE: text = "eslaf";
      KW_NIL:   text = {16'h0000, "lin"};
      default:  text = '0;
    endcase
    // text holds the word back to front so that byte idx is character idx
    return text[idx*8 +: 8];
  endfunction

  function automatic logic [FRAC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
    case (n)
      5'd0:    return 60'd1;
      5'd1:    return 60'd10;
      5'd2:    return 60'd100;
      5'd3:    return 60'd1000;
      5'd4:    return 60'd10000;
      5'd5:    return 60'd100000;
      5'd6:    return 60'd1000000;
      5'd7:    return 60'd10000000;
      5'd8:    return 60'd100000000;
      5'd9:    return 60'd1000000000;
      5'd10:   return 60'd10000000000;
      5'd11:   return 60'd100000000000;
      5'd12:   return 60'd1000000000000;
      5'd13:   return 60'd10000000000000;
      5'd14:   return 60'd100000000000000;
      5'd15:   return 60'd1000000000000000;
      5'd16:   return 60'd10000000000000000;
      5'd17:   return 60'd100000000000000000;
      default: return 60'd1000000000000000000;
    endcase
  endfunction

endpackage

// ===== src/sts_core.sv =====
// scanner state and per-byte next-state logic, up to two tokens per step
module sts_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    char_code,
  input  logic          end_of_source,
  output sts_pkg::res_t res0,
  output sts_pkg::res_t res1,
  output logic [1:0]    res_cnt
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_IDENT   = 4'd2;
  localparam logic [3:0] M_INT     = 4'd3;
  localparam logic [3:0] M_FRAC    = 4'd4;
  localparam logic [3:0] M_MINUS   = 4'd5;
  localparam logic [3:0] M_PERCENT = 4'd6;
  localparam logic [3:0] M_LESS    = 4'd7;
  localparam logic [3:0] M_GREATER = 4'd8;

  logic [3:0]                       mode_r, mode_nxt;
  logic [sts_pkg::LINE_W-1:0]       line_r, line_nxt, tline_r, tline_nxt;
  logic [sts_pkg::COL_W-1:0]        col_r, col_nxt, tcol_r, tcol_nxt;
  logic [sts_pkg::INT_W-1:0]        acc_r, acc_nxt;
  logic [sts_pkg::FRAC_W-1:0]       facc_r, facc_nxt;
  logic [sts_pkg::FCNT_W-1:0]       fcnt_r, fcnt_nxt;
  logic                             neg_r, neg_nxt;
  logic [sts_pkg::NLEN_W-1:0]       ilen_r, ilen_nxt;
  logic [1:0]                       kw_r, kw_nxt;

  logic [sts_pkg::COL_W-1:0]        col_inc;
  logic [sts_pkg::LINE_W-1:0]       line_inc;
  sts_pkg::res_t                    fin, st;
  logic                             fin_v, st_v, do_fs, kw_keep;
  logic [sts_pkg::INT_W-1:0]        digit64;
  logic [sts_pkg::FRAC_W-1:0]       digit60;

  assign col_inc  = (col_r < sts_pkg::COL_MAX) ? col_r + 1'b1 : col_r;
  assign line_inc = (line_r < sts_pkg::LINE_MAX) ? line_r + 1'b1 : line_r;
  assign digit64  = {{(sts_pkg::INT_W-4){1'b0}}, char_code[3:0]};
  assign digit60  = {{(sts_pkg::FRAC_W-4){1'b0}}, char_code[3:0]};
  assign kw_keep  = ({{(sts_pkg::NLEN_W-3){1'b0}}, sts_pkg::kw_len(kw_r)} > ilen_r) &&
                    (sts_pkg::kw_char(kw_r, ilen_r[2:0]) == char_code);

  // held token of the current mode
  always_comb begin
    fin               = '0;
    fin.line_number   = tline_r;
    fin.column_number = tcol_r;
    fin_v             = 1'b1;
    case (mode_r)
      M_IDENT: begin
        if (kw_r != sts_pkg::KW_NONE &&
            ilen_r == {{(sts_pkg::NLEN_W-3){1'b0}}, sts_pkg::kw_len(kw_r)}) begin
          fin.token_kind   = sts_pkg::KIND_LITERAL;
          fin.literal_kind = {1'b0, kw_r} + 3'd1;
        end else begin
          fin.token_kind  = sts_pkg::KIND_IDENT;
          fin.name_length = ilen_r;
        end
      end
      M_INT: begin
        fin.token_kind = sts_pkg::KIND_LITERAL;
        fin.int_value  = neg_r ? -acc_r : acc_r;
      end
      M_FRAC: begin
        fin.token_kind     = sts_pkg::KIND_LITERAL;
        fin.literal_kind   = sts_pkg::LIT_FRAC;
        fin.fraction_count = fcnt_r;
        // negative fractions floor the integer part and complement the digits
        if (neg_r && facc_r != '0) begin
          fin.int_value       = ~acc_r;
          fin.fraction_digits = sts_pkg::pow10(fcnt_r) - facc_r;
        end else begin
          fin.int_value       = neg_r ? -acc_r : acc_r;
          fin.fraction_digits = facc_r;
        end
      end
      M_MINUS:   fin.token_kind = sts_pkg::KIND_MINUS;
      M_PERCENT: fin.token_kind = sts_pkg::KIND_PERCENT;
      M_LESS:    fin.token_kind = sts_pkg::KIND_LT;
      M_GREATER: fin.token_kind = sts_pkg::KIND_GT;
      default:   fin_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    acc_nxt   = acc_r;
    facc_nxt  = facc_r;
    fcnt_nxt  = fcnt_r;
    neg_nxt   = neg_r;
    ilen_nxt  = ilen_r;
    kw_nxt    = kw_r;
    do_fs     = 1'b0;
    st        = '0;
    st_v      = 1'b0;
    res0      = '0;
    res1      = '0;
    res_cnt   = 2'd0;

    if (end_of_source) begin
      res0 = fin;
      st.token_kind    = sts_pkg::KIND_END;
      st.line_number   = line_r;
      st.column_number = col_r;
      st_v             = 1'b1;
      mode_nxt  = M_IDLE;
      line_nxt  = sts_pkg::LINE_W'(1);
      col_nxt   = sts_pkg::COL_W'(1);
      tline_nxt = sts_pkg::LINE_W'(1);
      tcol_nxt  = sts_pkg::COL_W'(1);
      acc_nxt   = '0;
      facc_nxt  = '0;
      fcnt_nxt  = '0;
      neg_nxt   = 1'b0;
      ilen_nxt  = '0;
      kw_nxt    = sts_pkg::KW_NONE;
    end else begin
      case (mode_r)
        M_COMMENT: begin
          if (char_code == 8'h0a) begin
            line_nxt = line_inc;
            col_nxt  = sts_pkg::COL_W'(1);
            mode_nxt = M_IDLE;
          end
        end
        M_IDENT: begin
          if (sts_pkg::is_ident_char(char_code)) begin
            if (kw_r != sts_pkg::KW_NONE && !kw_keep) kw_nxt = sts_pkg::KW_NONE;
            if (ilen_r != sts_pkg::NLEN_MAX) ilen_nxt = ilen_r + 1'b1;
            col_nxt = col_inc;
          end else begin
            do_fs = 1'b1;
          end
        end
        M_INT: begin
          if (sts_pkg::is_num_char(char_code)) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + digit64;
            col_nxt = col_inc;
          end else if (char_code == 8'h2e) begin
            mode_nxt = M_FRAC;
            col_nxt  = col_inc;
          end else begin
            do_fs = 1'b1;
          end
        end
        M_FRAC: begin
          if (sts_pkg::is_num_char(char_code)) begin
            if (fcnt_r < sts_pkg::FCNT_W'(sts_pkg::MAX_FRAC)) begin
              facc_nxt = (facc_r << 3) + (facc_r << 1) + digit60;
              fcnt_nxt = fcnt_r + 1'b1;
            end
            col_nxt = col_inc;
          end else begin
            do_fs = 1'b1;
          end
        end
        M_MINUS: begin
          if (sts_pkg::is_num_char(char_code)) begin
            mode_nxt = M_INT;
            neg_nxt  = 1'b1;
            acc_nxt  = digit64;
            col_nxt  = col_inc;
          end else begin
            do_fs = 1'b1;
          end
        end
        M_PERCENT, M_LESS, M_GREATER: begin
          if ((mode_r == M_PERCENT && char_code == 8'h7b) ||
              (mode_r != M_PERCENT && char_code == 8'h3d)) begin
            st.line_number   = tline_r;
            st.column_number = tcol_r;
            st.token_kind    = (mode_r == M_PERCENT) ? sts_pkg::KIND_MAP :
                               (mode_r == M_LESS) ? sts_pkg::KIND_LE : sts_pkg::KIND_GE;
            st_v     = 1'b1;
            mode_nxt = M_IDLE;
            col_nxt  = col_inc;
          end else begin
            do_fs = 1'b1;
          end
        end
        default: do_fs = 1'b1;
      endcase

      if (do_fs) begin
        // close the held token, then start on this byte
        mode_nxt  = M_IDLE;
        acc_nxt   = '0;
        facc_nxt  = '0;
        fcnt_nxt  = '0;
        neg_nxt   = 1'b0;
        ilen_nxt  = '0;
        kw_nxt    = sts_pkg::KW_NONE;
        tline_nxt = line_r;
        tcol_nxt  = col_r;
        st.line_number   = line_r;
        st.column_number = col_r;
        st_v    = 1'b1;
        col_nxt = col_inc;
        case (char_code)
          8'h5b: st.token_kind = sts_pkg::KIND_LBRACK;
          8'h5d: st.token_kind = sts_pkg::KIND_RBRACK;
          8'h28: st.token_kind = sts_pkg::KIND_LPAREN;
          8'h29: st.token_kind = sts_pkg::KIND_RPAREN;
          8'h7b: st.token_kind = sts_pkg::KIND_LBRACE;
          8'h7d: st.token_kind = sts_pkg::KIND_RBRACE;
          8'h3a: st.token_kind = sts_pkg::KIND_COLON;
          8'h7c: st.token_kind = sts_pkg::KIND_PIPE;
          8'h3d: st.token_kind = sts_pkg::KIND_EQ;
          8'h2c: st.token_kind = sts_pkg::KIND_COMMA;
          8'h2a: st.token_kind = sts_pkg::KIND_STAR;
          8'h2f: st.token_kind = sts_pkg::KIND_SLASH;
          8'h2b: st.token_kind = sts_pkg::KIND_PLUS;
          8'h23: begin
            st_v     = 1'b0;
            col_nxt  = col_r;
            mode_nxt = M_COMMENT;
          end
          8'h0a: begin
            st_v     = 1'b0;
            line_nxt = line_inc;
            col_nxt  = sts_pkg::COL_W'(1);
          end
          8'h20, 8'h0d, 8'h09: st_v = 1'b0;
          8'h2d: begin
            st_v     = 1'b0;
            mode_nxt = M_MINUS;
          end
          8'h25: begin
            st_v     = 1'b0;
            mode_nxt = M_PERCENT;
          end
          8'h3c: begin
            st_v     = 1'b0;
            mode_nxt = M_LESS;
          end
          8'h3e: begin
            st_v     = 1'b0;
            mode_nxt = M_GREATER;
          end
          default: begin
            if (sts_pkg::is_letter(char_code) || char_code == 8'h5f || char_code == 8'h3f) begin
              st_v     = 1'b0;
              mode_nxt = M_IDENT;
              ilen_nxt = sts_pkg::NLEN_W'(1);
              kw_nxt   = (char_code == 8'h74) ? sts_pkg::KW_TRUE :
                         (char_code == 8'h66) ? sts_pkg::KW_FALSE :
                         (char_code == 8'h6e) ? sts_pkg::KW_NIL : sts_pkg::KW_NONE;
            end else if (sts_pkg::is_num_char(char_code)) begin
              st_v     = 1'b0;
              mode_nxt = M_INT;
              acc_nxt  = digit64;
            end else begin
              st.token_kind = sts_pkg::KIND_ERROR;
            end
          end
        endcase
      end
    end

    // held token goes first when there is one
    if ((end_of_source || do_fs) && fin_v) begin
      res0 = fin;
      res1 = st;
      res_cnt = st_v ? 2'd2 : 2'd1;
    end else begin
      res0 = st;
      res_cnt = {1'b0, st_v};
    end
    if (res_cnt == 2'd1) res0.last = 1'b1;
    if (res_cnt == 2'd2) res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      line_r  <= sts_pkg::LINE_W'(1);
      col_r   <= sts_pkg::COL_W'(1);
      tline_r <= sts_pkg::LINE_W'(1);
      tcol_r  <= sts_pkg::COL_W'(1);
      acc_r   <= '0;
      facc_r  <= '0;
      fcnt_r  <= '0;
      neg_r   <= 1'b0;
      ilen_r  <= '0;
      kw_r    <= sts_pkg::KW_NONE;
    end else if (step) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
      acc_r   <= acc_nxt;
      facc_r  <= facc_nxt;
      fcnt_r  <= fcnt_nxt;
      neg_r   <= neg_nxt;
      ilen_r  <= ilen_nxt;
      kw_r    <= kw_nxt;
    end
  end

  a_eos_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (step && end_of_source) |=> (mode_r == M_IDLE && line_r == sts_pkg::LINE_W'(1) &&
                                 col_r == sts_pkg::COL_W'(1)))
    else $error("scanner state not back to start after end of source");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (res_cnt == 2'd2) |-> (!res0.last && res1.last))
    else $error("last flag misplaced on a two-token step");

  a_frac_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= sts_pkg::FCNT_W'(sts_pkg::MAX_FRAC))
    else $error("fraction digit count beyond limit");

endmodule

// ===== src/source_token_scanner.sv =====
// top level of the source token scanner: input register, scanner core, token queue
//
//  channel | ports                                   | carries
//  --------+-----------------------------------------+--------------------------------
//  in      | in_valid, in_ready, in_char_code,       | one source byte or end marker
//          | in_end_of_source                        |
//  out     | out_valid, out_ready, out_token_kind .. | one token with position, value,
//          | out_last                                | name length and last flag
//
// one request per cycle is taken while in_ready is high; a byte that closes a held
// token and starts another gives two tokens, and the four-entry token queue drains
// them at one per cycle while out_ready is high. a request is registered, then
// scanned once the queue has room. reset brings line and column to one and empties
// the queue. in_ready drops only while a request waits and the queue has fewer than
// two free entries, so a stalled out side does not lose or repeat tokens.
module source_token_scanner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_char_code,
  input  logic                                in_end_of_source,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [4:0]                          out_token_kind,
  output logic [2:0]                          out_literal_kind,
  output logic [sts_pkg::LINE_W-1:0]          out_line_number,
  output logic [sts_pkg::COL_W-1:0]           out_column_number,
  output logic signed [sts_pkg::INT_W-1:0]    out_int_value,
  output logic [sts_pkg::FRAC_W-1:0]          out_fraction_digits,
  output logic [sts_pkg::FCNT_W-1:0]          out_fraction_count,
  output logic [sts_pkg::NLEN_W-1:0]          out_name_length,
  output logic                                out_last
);

  logic                        s_vld_r;
  logic [7:0]                  s_char_r;
  logic                        s_eos_r;
  logic                        step, pop;
  sts_pkg::res_t               res0, res1;
  logic [1:0]                  res_cnt;
  sts_pkg::res_t               q_r [sts_pkg::QDEPTH];
  sts_pkg::res_t               q_nxt [sts_pkg::QDEPTH];
  sts_pkg::res_t               q_sh [sts_pkg::QDEPTH];
  logic [sts_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt, base;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign step      = s_vld_r && (cnt_r <= sts_pkg::QCNT_W'(sts_pkg::QDEPTH - 2));
  assign in_ready  = !s_vld_r || step;
  assign base      = cnt_r - {{(sts_pkg::QCNT_W-1){1'b0}}, pop};
  assign cnt_nxt   = base + (step ? {{(sts_pkg::QCNT_W-2){1'b0}}, res_cnt} : '0);

  sts_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .char_code     (s_char_r),
    .end_of_source (s_eos_r),
    .res0          (res0),
    .res1          (res1),
    .res_cnt       (res_cnt)
  );

  always_comb begin
    for (int i = 0; i < sts_pkg::QDEPTH - 1; i++) q_sh[i] = q_r[i+1];
    q_sh[sts_pkg::QDEPTH-1] = q_r[sts_pkg::QDEPTH-1];
    for (int i = 0; i < sts_pkg::QDEPTH; i++) begin
      q_nxt[i] = pop ? q_sh[i] : q_r[i];
      if (step && res_cnt != 2'd0 && base == sts_pkg::QCNT_W'(i)) q_nxt[i] = res0;
      if (step && res_cnt == 2'd2 && base + 1'b1 == sts_pkg::QCNT_W'(i)) q_nxt[i] = res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (in_ready) s_vld_r <= in_valid;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_char_r <= in_char_code;
      s_eos_r  <= in_end_of_source;
    end
    q_r <= q_nxt;
  end

  assign out_token_kind      = q_r[0].token_kind;
  assign out_literal_kind    = q_r[0].literal_kind;
  assign out_line_number     = q_r[0].line_number;
  assign out_column_number   = q_r[0].column_number;
  assign out_int_value       = q_r[0].int_value;
  assign out_fraction_digits = q_r[0].fraction_digits;
  assign out_fraction_count  = q_r[0].fraction_count;
  assign out_name_length     = q_r[0].name_length;
  assign out_last            = q_r[0].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sts_pkg::QCNT_W'(sts_pkg::QDEPTH))
    else $error("token queue overfilled");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_cnt != 2'd0) |=> out_valid)
    else $error("scanned token not offered");

  a_pair_together: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !q_r[0].last) |-> (cnt_r >= sts_pkg::QCNT_W'(2)))
    else $error("first token of a pair left without its partner");

endmodule
